>>> src/dph_pkg.sv
// Package for the duplicate packet history block.
// Holds the history entry type and the request bundle to the history store.
// No dependencies.
`timescale 1ns / 1ps

package dph_pkg;

    localparam int SEQ_W  = 16;
    localparam int ADDR_W = 16;

    // One history entry: {sequence number, source short, destination short}.
    typedef struct packed {
        logic [SEQ_W-1:0]  seq_number;
        logic [ADDR_W-1:0] source_short;
        logic [ADDR_W-1:0] dest_short;
    } t_entry;

    // Command codes carried by the command field.
    localparam logic CMD_CHECK    = 1'b0;
    localparam logic CMD_REGISTER = 1'b1;

    // Request from the pipeline to the history store for one beat.
    typedef struct packed {
        logic   step;   // a beat is being processed this cycle
        logic   push;   // register the probe triple at the front
        t_entry probe;  // triple to compare and, on push, to store
    } t_hist_req;

endpackage

>>> src/dph_history.sv
// History store: registered entries, parallel match and front insertion.
// Depends on dph_pkg.
`timescale 1ns / 1ps

module dph_history #(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dph_pkg::t_hist_req i_req,
    output logic               o_hit
);
    import dph_pkg::*;

    t_entry [HISTORY_DEPTH-1:0] r_hist;
    t_entry [HISTORY_DEPTH-1:0] n_hist;
    logic   [HISTORY_DEPTH-1:0] hits;

    // Compare against the history as it stands before this beat.
    always_comb begin
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hits[k] = (r_hist[k] == i_req.probe);
        end
    end

    assign o_hit = |hits;

    // Shift down by one, newest at entry 0; oldest falls off.
    always_comb begin
        n_hist = r_hist;
        if (i_req.step && i_req.push) begin
            for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
                n_hist[k] = r_hist[k-1];
            end
            n_hist[0] = i_req.probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else begin
            r_hist <= n_hist;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.step && i_req.push) |=> (r_hist[0] == $past(i_req.probe)))
        else $error("registered triple not at front of history");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.step && i_req.push) |=> $stable(r_hist))
        else $error("history changed without a register beat");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_hist == '0))
        else $error("history not cleared by reset");
`endif

endmodule

>>> src/duplicate_packet_history.sv
// Top level of the duplicate packet history block.
// Input register, history store (dph_history) and result register.
// Depends on dph_pkg and dph_history.
`timescale 1ns / 1ps

// Duplicate packet history. Each input beat carries a command (check or
// register) and a triple {seq_number, source_short, dest_short}; each beat
// yields exactly one result beat whose is_duplicate flag tells whether any
// of the HISTORY_DEPTH stored entries matched the whole triple before that
// beat. A register beat also pushes the triple to the front of the history
// and drops the oldest entry, even when it was already stored. Reset clears
// every entry to zero, so an all-zero triple reads as a duplicate until the
// history has been filled. The block takes one beat per clock while the output
// is not stalled: a beat is held in the input register, then compared against
// all entries in parallel and shifted in while the flag is loaded into the
// result register. That single compare-and-shift stage on the registered
// history sets the rate. Output stall back-pressures the input side only when
// both the result register and the input register are full.
module duplicate_packet_history #(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [dph_pkg::SEQ_W-1:0]   i_seq_number,
    input  logic [dph_pkg::ADDR_W-1:0]  i_source_short,
    input  logic [dph_pkg::ADDR_W-1:0]  i_dest_short,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_is_duplicate
);
    import dph_pkg::*;

    // input register
    logic      r_in_valid;
    logic      r_command;
    t_entry    r_triple;

    // result register
    logic      r_out_valid;
    logic      r_dup;

    logic      adv;       // input register moves into the result stage
    logic      in_take;   // input beat accepted
    logic      hit;
    t_hist_req hist_req;

    // Result stage can load when empty or being drained this cycle.
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    assign hist_req.step  = adv;
    assign hist_req.push  = (r_command == CMD_REGISTER);
    assign hist_req.probe = r_triple;

    dph_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hist_req),
        .o_hit   (hit)
    );

    // Input register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command             <= i_command;
            r_triple.seq_number   <= i_seq_number;
            r_triple.source_short <= i_source_short;
            r_triple.dest_short   <= i_dest_short;
        end
    end

    // Result register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload (flag from history before the shift)
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dup <= hit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_duplicate = r_dup;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while pipeline has room");

    a_no_lost_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_triple)))
        else $error("held beat lost or changed in input register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (o_out_valid && (o_is_duplicate == $past(hit))))
        else $error("result register did not capture the match flag");
`endif

endmodule

>>> verif/tb_duplicate_packet_history.sv
// Self-checking testbench for duplicate_packet_history: a directed table and then random
// beats under four idle/stall phases, scored against an in-bench model of the history.
// Depends on dph_pkg and the duplicate_packet_history RTL.
`timescale 1ns / 1ps

module tb_duplicate_packet_history;

    import dph_pkg::*;

    localparam int DEPTH        = 4;
    localparam int BEATS_PER_PH = 400;     // random beats in each of the four phases
    localparam int POOL_SIZE    = 8;       // recently registered triples reused as stimulus
    localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 8;       // extra wait after the last owed flag

    // One directed row. When known is set, dup is the flag read straight off the
    // behavior; otherwise the history model supplies the expectation.
    typedef struct packed {
        logic        cmd;
        logic [15:0] seq;
        logic [15:0] src;
        logic [15:0] dst;
        logic        known;
        logic        dup;
    } stim_row_t;

    localparam int N_ROWS = 17;
    localparam stim_row_t DIR_ROWS [0:N_ROWS-1] = '{
        // cleared entries match an all-zero triple
        '{CMD_CHECK,    16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1},
        // registering a stored triple still reports it and stores it again
        '{CMD_REGISTER, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1},
        '{CMD_CHECK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0},
        '{CMD_REGISTER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0},
        '{CMD_CHECK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1},
        // a single differing field is not a match
        '{CMD_CHECK,    16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1, 1'b0},
        '{CMD_CHECK,    16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b1, 1'b0},
        '{CMD_CHECK,    16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0},
        // fill the history so the zero entries age out
        '{CMD_REGISTER, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0},
        '{CMD_REGISTER, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0},
        '{CMD_REGISTER, 16'h0001, 16'h8000, 16'h7FFF, 1'b0, 1'b0},
        '{CMD_CHECK,    16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
        // oldest entry still hits, then gets pushed out
        '{CMD_CHECK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
        '{CMD_REGISTER, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, 1'b0},
        '{CMD_CHECK,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
        '{CMD_CHECK,    16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0},
        '{CMD_REGISTER, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0}
    };

    // DUT signals; every input is known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_command      = CMD_CHECK;
    logic [15:0] i_seq_number   = '0;
    logic [15:0] i_source_short = '0;
    logic [15:0] i_dest_short   = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic        o_is_duplicate;

    // Side-band that travels with the beat on the input port: typed expectation, if any.
    // Driven with nonblocking assignments like the payload, so the scoreboard sees
    // the value that belongs to the beat accepted at that edge.
    logic        beat_known     = 1'b0;
    logic        beat_dup       = 1'b0;

    // Bench state
    t_entry      model_hist [DEPTH];       // mirror of the block's history, entry 0 newest
    logic        dup_flags_due [$];        // flags still owed by the block, oldest first
    t_entry      recent_regs [$];          // stimulus pool of recently registered triples
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          err_count     = 0;
    int          cycle_count   = 0;

    duplicate_packet_history #(
        .HISTORY_DEPTH (DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_seq_number   (i_seq_number),
        .i_source_short (i_source_short),
        .i_dest_short   (i_dest_short),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_duplicate (o_is_duplicate)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Compare the probe against every stored entry, then shift it in on a register.
    // The returned flag reflects the history before the shift.
    function automatic logic track_history(logic cmd, t_entry probe);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (model_hist[k] == probe) hit = 1'b1;
        end
        if (cmd == CMD_REGISTER) begin
            for (int k = DEPTH - 1; k > 0; k--) model_hist[k] = model_hist[k-1];
            model_hist[0] = probe;
        end
        return hit;
    endfunction

    // Random triple, biased toward recent registrations so hits and near misses
    // are common; the rest is small values and fully random noise.
    function automatic t_entry pick_triple();
        t_entry t;
        int     mode;
        int     flip;
        mode = $urandom_range(9);
        if (mode <= 6 && recent_regs.size() > 0) begin
            t = recent_regs[$urandom_range(recent_regs.size() - 1)];
            if (mode >= 5) begin
                // near miss: one bit flipped somewhere in the triple
                flip = $urandom_range(47);
                t[flip] = ~t[flip];
            end
        end else if (mode == 7) begin
            t.seq_number   = 16'($urandom_range(3));
            t.source_short = 16'($urandom_range(3));
            t.dest_short   = 16'($urandom_range(3));
        end else begin
            t = t_entry'(48'({$urandom, $urandom}));
        end
        return t;
    endfunction

    // Present one beat and hold it until accepted. Idle cycles come first, at the
    // phase's rate; each cycle gets at most one write to i_in_valid.
    task automatic send_beat(logic cmd, t_entry t, logic known, logic dup);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_seq_number   <= t.seq_number;
        i_source_short <= t.source_short;
        i_dest_short   <= t.dest_short;
        beat_known     <= known;
        beat_dup       <= dup;
        // outputs read right after the edge still hold their pre-edge values
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_REGISTER) begin
            recent_regs.push_back(t);
            if (recent_regs.size() > POOL_SIZE) void'(recent_regs.pop_front());
        end
    endtask

    // Receiver back-pressure at the phase's rate
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Scoreboard: an accepted input beat queues its flag; an accepted result beat
    // is checked against the oldest queued flag.
    always @(posedge i_clk) begin
        logic   flag;
        t_entry probe;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                probe = '{i_seq_number, i_source_short, i_dest_short};
                flag  = track_history(i_command, probe);
                dup_flags_due.push_back(beat_known ? beat_dup : flag);
            end
            if (o_out_valid && !i_out_stall) begin
                if (dup_flags_due.size() == 0) begin
                    $error("unexpected result beat: is_duplicate=%0b", o_is_duplicate);
                    err_count++;
                end else begin
                    flag = dup_flags_due.pop_front();
                    if (o_is_duplicate !== flag) begin
                        $error("is_duplicate: expected %0b, actual %0b", flag, o_is_duplicate);
                        err_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_entry t;
        for (int k = 0; k < DEPTH; k++) model_hist[k] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, no idling
        for (int r = 0; r < N_ROWS; r++) begin
            t = '{DIR_ROWS[r].seq, DIR_ROWS[r].src, DIR_ROWS[r].dst};
            send_beat(DIR_ROWS[r].cmd, t, DIR_ROWS[r].known, DIR_ROWS[r].dup);
        end

        // Random phases: free flow, sender idle, receiver stall, light mix of both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            repeat (BEATS_PER_PH) begin
                t = pick_triple();
                send_beat(logic'($urandom_range(1)), t, 1'b0, 1'b0);
            end
        end

        // Drain: stop sending, release the output, wait for every owed flag
        i_in_valid <= 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        while (dup_flags_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (dup_flags_due.size() != 0) begin
            $error("missing result beats: %0d still owed", dup_flags_due.size());
            err_count++;
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
